@@ design/tsp_pkg.sv @@
// Shared constants, state encoding and control structs for the section packetizer.
package tsp_pkg;

  localparam int PAYLOAD_BYTES = 184;
  localparam int POS_W = 8;
  localparam int IDX_W = 6;
  localparam int PID_W = 13;
  localparam int CC_W = 4;
  localparam int LAST_WORD = (PAYLOAD_BYTES - 1) / 4;

  localparam logic [7:0] STUFF_BYTE = 8'hFF;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_PAD
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic push;         // place one byte this cycle
    logic sel_stuff;    // byte is stuffing rather than the input byte
    logic end_section;  // section finished: next packet is a first packet
    logic run_last;     // a word emitted by this push closes the input's run
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;    // output register can take a word this cycle
    logic push_done;    // the byte placed now completes the packet payload
  } status_t;

endpackage

@@ design/tsp_ctrl.sv @@
// Controller state machine: byte acceptance and end-of-section stuffing sequence.
module tsp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            section_end_i,
  output logic            in_ready_o,
  input  tsp_pkg::status_t status_i,
  output tsp_pkg::cmd_t   cmd_o
);
  import tsp_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && status_i.slot_free && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && section_end_i && !status_i.push_done) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (status_i.slot_free && status_i.push_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o         = status_i.slot_free;
        cmd_o.push         = accept;
        cmd_o.end_section  = accept && section_end_i && status_i.push_done;
        cmd_o.run_last     = status_i.push_done || !section_end_i;
      end
      ST_PAD: begin
        cmd_o.push         = status_i.slot_free;
        cmd_o.sel_stuff    = 1'b1;
        cmd_o.end_section  = status_i.slot_free && status_i.push_done;
        cmd_o.run_last     = status_i.push_done;
      end
      default: begin
        in_ready_o = 1'b0;
        cmd_o      = '0;
      end
    endcase
  end

endmodule

@@ design/tsp_datapath.sv @@
// Datapath: payload position, word assembly, packet header fields and output register.
module tsp_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [tsp_pkg::PID_W-1:0] cfg_stream_pid_i,
  input  logic [7:0]                section_byte_i,
  input  tsp_pkg::cmd_t             cmd_i,
  output tsp_pkg::status_t          status_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [31:0]               payload_word_o,
  output logic [tsp_pkg::IDX_W-1:0] word_index_o,
  output logic                      unit_start_o,
  output logic [tsp_pkg::CC_W-1:0]  continuity_o,
  output logic [tsp_pkg::PID_W-1:0] header_pid_o,
  output logic                      packet_done_o,
  output logic                      run_last_o
);
  import tsp_pkg::*;

  logic [PID_W-1:0] pid_q;
  logic [POS_W-1:0] pos_q, pos_eff, pos_new;
  logic             first_q;
  logic [CC_W-1:0]  cc_q;
  logic [23:0]      buf_q;
  logic [1:0]       bcnt_q, bcnt_eff;
  logic [2:0]       cnt;
  logic             ptr_ins, done, emit, slot_free;
  logic [7:0]       byte_in;
  logic [31:0]      word;
  logic             out_valid_q;

  // Pointer byte of a section's first packet: the buffer is already zero, so
  // inserting it only advances the position and byte count by one.
  assign ptr_ins  = !cmd_i.sel_stuff && (pos_q == '0) && first_q;
  assign pos_eff  = pos_q + POS_W'(ptr_ins);
  assign bcnt_eff = bcnt_q + 2'(ptr_ins);
  assign cnt      = {1'b0, bcnt_eff} + 3'd1;
  assign pos_new  = pos_eff + POS_W'(1);
  assign done     = (pos_new >= POS_W'(PAYLOAD_BYTES));
  assign emit     = (cnt == 3'd4) || done;
  assign byte_in  = cmd_i.sel_stuff ? STUFF_BYTE : section_byte_i;

  assign slot_free          = !out_valid_q || out_ready_i;
  assign status_o.slot_free = slot_free;
  assign status_o.push_done = done;

  // Short final words keep their bytes high and stuff the rest.
  always_comb begin
    case (cnt)
      3'd1:    word = {byte_in, {3{STUFF_BYTE}}};
      3'd2:    word = {buf_q[7:0], byte_in, {2{STUFF_BYTE}}};
      3'd3:    word = {buf_q[15:0], byte_in, STUFF_BYTE};
      default: word = {buf_q, byte_in};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q   <= '0;
      pos_q   <= '0;
      first_q <= 1'b1;
      cc_q    <= '0;
      buf_q   <= '0;
      bcnt_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        pid_q <= cfg_stream_pid_i;
      end
      if (cmd_i.push) begin
        if (emit) begin
          buf_q  <= '0;
          bcnt_q <= '0;
        end else begin
          buf_q  <= {buf_q[15:0], byte_in};
          bcnt_q <= cnt[1:0];
        end
        // A packet closed by the end of its section makes the next one a first packet.
        if (done) begin
          pos_q   <= '0;
          first_q <= cmd_i.end_section;
          cc_q    <= cc_q + CC_W'(1);
        end else begin
          pos_q <= pos_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && emit) begin
      payload_word_o <= word;
      word_index_o   <= pos_eff[POS_W-1:2];
      unit_start_o   <= first_q;
      continuity_o   <= cc_q;
      header_pid_o   <= pid_q;
      packet_done_o  <= done;
      run_last_o     <= cmd_i.run_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/ts_section_packetizer_top.sv @@
// Top level of the transport-stream section packetizer.
//
//  Channel  Direction  Handshake                 Word
//  -------  ---------  ------------------------  -----------------------------------------
//  input    in         in_valid_i / in_ready_o   section_byte_i, section_end_i
//  output   out        out_valid_o / out_ready_i payload_word_o and the packet header fields
//  config   in         cfg_valid_i / cfg_ready_o cfg_stream_pid_i
//
// A section byte is taken in a single push, the pointer byte of a first packet included.
// After the last byte of a section, the packet is padded with stuffing at one byte per
// cycle while the output register can take a word, and the input stalls until the
// padding is done; the single byte-push path in the datapath sets the rate.
// The input also stalls whenever the output register is full and not being taken.
// Reset is asynchronous and active low; the block comes out of reset ready, with the
// continuity counter at zero and the next packet marked as a section start.
// The configuration port is always ready; write it only while the block is idle.
module ts_section_packetizer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tsp_pkg::PID_W-1:0] cfg_stream_pid_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                section_byte_i,
  input  logic                      section_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [31:0]               payload_word_o,
  output logic [tsp_pkg::IDX_W-1:0] word_index_o,
  output logic                      unit_start_o,
  output logic [tsp_pkg::CC_W-1:0]  continuity_o,
  output logic [tsp_pkg::PID_W-1:0] header_pid_o,
  output logic                      packet_done_o,
  output logic                      run_last_o
);
  import tsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The stream PID register has no side effects, so writes are always taken.
  assign cfg_ready_o = 1'b1;

  // The controller decides which byte is pushed each cycle and when the section ends.
  tsp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .section_end_i (section_end_i),
    .in_ready_o    (in_ready_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // The datapath packs bytes into words and holds the output register.
  tsp_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_stream_pid_i (cfg_stream_pid_i),
    .section_byte_i   (section_byte_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .payload_word_o   (payload_word_o),
    .word_index_o     (word_index_o),
    .unit_start_o     (unit_start_o),
    .continuity_o     (continuity_o),
    .header_pid_o     (header_pid_o),
    .packet_done_o    (packet_done_o),
    .run_last_o       (run_last_o)
  );

endmodule

@@ design/tsp_checker.sv @@
// Port-level checker for the section packetizer and its bind to the top level.
module tsp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [31:0]               payload_word_o,
  input logic [tsp_pkg::IDX_W-1:0] word_index_o,
  input logic                      unit_start_o,
  input logic [tsp_pkg::CC_W-1:0]  continuity_o,
  input logic [tsp_pkg::PID_W-1:0] header_pid_o,
  input logic                      packet_done_o,
  input logic                      run_last_o
);
  import tsp_pkg::*;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_word_o)
      && $stable(word_index_o) && $stable(packet_done_o) && $stable(unit_start_o)
      && $stable(continuity_o) && $stable(header_pid_o) && $stable(run_last_o))
    else $error("output word changed while stalled");

  // The packet closes exactly on its last word position.
  a_done_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_done_o |-> word_index_o == IDX_W'(LAST_WORD))
    else $error("packet done on wrong word index");

  a_open_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !packet_done_o |-> word_index_o < IDX_W'(LAST_WORD))
    else $error("packet not closed at its last word");

  // A full output register that is not being taken stalls the input.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the output register is blocked");

  // The stream PID register always takes a write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not taken");

endmodule

bind ts_section_packetizer_top tsp_checker u_tsp_checker (.*);
